@@ src/kts_pkg.sv @@
`default_nettype none
package kts_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ZSPAN = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	// dividend is |t - t0| (33 bits) shifted up by 16
	localparam int DIV_NW = 49;
	localparam int DIV_DW = 33;
	localparam int PROD_W = 81;

	typedef struct packed {
		logic               kind;
		logic               restart;
		logic [31:0]        time_q16;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic        op;
		logic        restart;
		logic [31:0] tq;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic [31:0] tk;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
	} key_t;

endpackage
`default_nettype wire

@@ src/keyframe_track_sampler.sv @@
// keyframe track sampler
// req channel: one word per item, kind 0 appends a key (restart empties the
// track first), kind 1 samples the track at time_q16. rsp channel: one word per
// sample, none per load. both channels move a word when valid is high and
// stall is low.
// a two-word queue takes requests while the back end works, so req_stall rises
// only when that queue is full.
// a load is handled in the back end without leaving its idle state. a sample
// leaves the queue, runs a linear scan up to the first key not earlier than
// the query (or up to the last key), reads two keys, runs the bit-serial
// divider (skipped for a zero span), then for each component does the
// 16-bit-chunk multiply and saturation, and goes into the output register.
// empty and single-key tracks skip the scan, key reads, divide and multiply.
// reset empties the track, the request queue and the output register; key storage is not cleared.
// while rsp_stall is high the finished word waits in the output register and
// the back end holds at its last step; requests keep filling the queue.
`default_nettype none
module keyframe_track_sampler
	import kts_pkg::*;
#(
	parameter int MAX_KEYS = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	head_t head;
	logic  pop;

	kts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	kts_back #(
		.MAX_KEYS (MAX_KEYS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

@@ src/kts_front.sv @@
`default_nettype none
module kts_front
	import kts_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_stall,
	input  wire req_t  req,
	output head_t      head,
	input  wire logic  pop
);

	cmd_t       buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;
	cmd_t       cmd;

	assign req_stall = (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign do_pop    = pop && (cnt_q != 2'd0);

	always_comb begin
		cmd.op      = req.kind ? OP_SAMPLE : OP_LOAD;
		cmd.restart = req.restart;
		cmd.tq      = req.time_q16;
		cmd.vx      = req.in_x;
		cmd.vy      = req.in_y;
		cmd.vz      = req.in_z;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = buf_q[rp_q];

endmodule
`default_nettype wire

@@ src/kts_div.sv @@
`default_nettype none
module kts_div
	import kts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] dividend,
	input  wire logic [DIV_DW-1:0] divisor,
	output logic                   done,
	output logic [DIV_NW-1:0]      quotient
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dv_q;
	logic [DIV_NW-1:0] quo_q;
	logic [5:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   sh;
	logic              fits;

	assign sh   = {rem_q, quo_q[DIV_NW-1]};
	assign fits = (sh >= {1'b0, dv_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dv_q  <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(sh - {1'b0, dv_q}) : sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ src/kts_back.sv @@
`default_nettype none
module kts_back
	import kts_pkg::*;
#(
	parameter int MAX_KEYS = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire head_t head,
	output logic       pop,
	output logic       rsp_valid,
	input  wire logic  rsp_stall,
	output rsp_t       rsp
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SINGLE = 4'd1;
	localparam logic [3:0] S_SRD    = 4'd2;
	localparam logic [3:0] S_SCMP   = 4'd3;
	localparam logic [3:0] S_RD0    = 4'd4;
	localparam logic [3:0] S_CAP0   = 4'd5;
	localparam logic [3:0] S_CAP1   = 4'd6;
	localparam logic [3:0] S_PREP   = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_MUL    = 4'd9;
	localparam logic [3:0] S_MQ     = 4'd10;
	localparam logic [3:0] S_MV     = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	key_t               mem [MAX_KEYS];
	key_t               rd_q;
	logic [AW-1:0]      ra;
	logic               we;
	logic [AW-1:0]      wa;
	key_t               wd;

	logic [3:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [31:0]        t_q;
	logic [AW-1:0]      i0_q;
	logic [AW-1:0]      i1_q;
	logic [31:0]        t0_q;
	logic [31:0]        t1_q;
	logic [31:0]        v0_q [3];
	logic [31:0]        v1_q [3];
	logic [31:0]        res_q [3];
	logic [1:0]         st_q;
	logic               fneg_q;
	logic [DIV_NW-1:0]  af_q;
	logic [1:0]         comp_q;
	logic [1:0]         chunk_q;
	logic [PROD_W-1:0]  acc_q;
	logic [40:0]        q_q;
	logic               out_v_q;
	rsp_t               out_q;

	logic [CW-1:0]      base;
	logic               hit;
	logic [CW-1:0]      lbv;
	logic [CW-1:0]      i0v;
	logic [CW:0]        i1n;
	logic signed [32:0] num;
	logic signed [32:0] den;
	logic [32:0]        an;
	logic [32:0]        adn;
	logic               div_start;
	logic               div_done;
	logic [DIV_NW-1:0]  div_q;
	logic signed [32:0] diff;
	logic               neg;
	logic [32:0]        ad;
	logic [63:0]        af_pad;
	logic [15:0]        fchunk;
	logic [48:0]        pp;
	logic signed [41:0] vsum;
	logic [31:0]        vsat;
	logic               sat;
	logic               out_free;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign base = head.cmd.restart ? '0 : cnt_q;
	assign wa   = base[AW-1:0];
	assign wd   = '{tk: head.cmd.tq, vx: head.cmd.vx, vy: head.cmd.vy, vz: head.cmd.vz};
	assign we   = (state_q == S_IDLE) && head.valid && (head.cmd.op == OP_LOAD)
		&& (base < CW'(MAX_KEYS));
	assign pop  = (state_q == S_IDLE) && head.valid;

	assign hit = (rd_q.tk >= t_q);
	assign lbv = hit ? idx_q : cnt_q;
	assign i0v = (lbv == '0) ? '0 : CW'(lbv - 1'b1);
	assign i1n = {1'b0, i0v} + 1'b1;

	always_comb begin
		unique case (state_q)
			S_SRD:   ra = idx_q[AW-1:0];
			S_RD0:   ra = i0_q;
			S_CAP0:  ra = i1_q;
			default: ra = '0;
		endcase
	end

	assign num = $signed({1'b0, t_q}) - $signed({1'b0, t0_q});
	assign den = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
	assign an  = num[32] ? 33'(-num) : num;
	assign adn = den[32] ? 33'(-den) : den;
	assign div_start = (state_q == S_PREP) && (den != '0);

	kts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({an, 16'd0}),
		.divisor  (adn),
		.done     (div_done),
		.quotient (div_q)
	);

	assign diff   = $signed({v1_q[comp_q][31], v1_q[comp_q]})
		- $signed({v0_q[comp_q][31], v0_q[comp_q]});
	assign neg    = diff[32] ^ fneg_q;
	assign ad     = diff[32] ? 33'(-diff) : diff;
	assign af_pad = {{(64 - DIV_NW){1'b0}}, af_q};
	assign fchunk = af_pad[{chunk_q, 4'd0} +: 16];
	assign pp     = ad * fchunk;

	assign vsum = $signed({{10{v0_q[comp_q][31]}}, v0_q[comp_q]})
		+ (neg ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q}));
	always_comb begin
		sat  = 1'b0;
		vsat = vsum[31:0];
		if (!vsum[41] && (vsum[40:31] != '0)) begin
			sat  = 1'b1;
			vsat = 32'h7fff_ffff;
		end else if (vsum[41] && (vsum[40:31] != '1)) begin
			sat  = 1'b1;
			vsat = 32'h8000_0000;
		end
	end

	assign out_free = !out_v_q || !rsp_stall;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q   <= head.cmd.tq;
				idx_q <= '0;
				for (int c = 0; c < 3; c++) begin
					res_q[c] <= '0;
				end
				st_q <= ST_EMPTY;
			end
			S_SINGLE: begin
				res_q[0] <= rd_q.vx;
				res_q[1] <= rd_q.vy;
				res_q[2] <= rd_q.vz;
				st_q     <= ST_OK;
			end
			S_SCMP: begin
				idx_q <= CW'(idx_q + 1'b1);
				i0_q  <= i0v[AW-1:0];
				i1_q  <= (i1n >= {1'b0, cnt_q}) ? '0 : i1n[AW-1:0];
			end
			S_CAP0: begin
				t0_q    <= rd_q.tk;
				v0_q[0] <= rd_q.vx;
				v0_q[1] <= rd_q.vy;
				v0_q[2] <= rd_q.vz;
			end
			S_CAP1: begin
				t1_q    <= rd_q.tk;
				v1_q[0] <= rd_q.vx;
				v1_q[1] <= rd_q.vy;
				v1_q[2] <= rd_q.vz;
			end
			S_PREP: begin
				fneg_q  <= num[32] ^ den[32];
				af_q    <= '0;
				st_q    <= (den == '0) ? ST_ZSPAN : ST_OK;
				comp_q  <= '0;
				chunk_q <= '0;
				acc_q   <= '0;
			end
			S_DIV: begin
				af_q <= div_q;
			end
			S_MUL: begin
				acc_q   <= acc_q + (PROD_W'(pp) << {chunk_q, 4'd0});
				chunk_q <= chunk_q + 2'd1;
			end
			S_MQ: begin
				if (acc_q[PROD_W-1:56] != '0) begin
					q_q <= 41'h100_0000_0000;
				end else begin
					q_q <= {1'b0, acc_q[55:16]} + {40'd0, neg && (acc_q[15:0] != '0)};
				end
			end
			S_MV: begin
				res_q[comp_q] <= vsat;
				if (sat) begin
					st_q <= ST_SAT;
				end
				comp_q  <= comp_q + 2'd1;
				chunk_q <= '0;
				acc_q   <= '0;
			end
			default: begin
			end
		endcase
		if (state_q == S_FIN && out_free) begin
			out_q.out_x  <= res_q[0];
			out_q.out_y  <= res_q[1];
			out_q.out_z  <= res_q[2];
			out_q.status <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						if (head.cmd.op == OP_LOAD) begin
							cnt_q <= we ? CW'(base + 1'b1) : base;
						end else if (cnt_q == '0) begin
							state_q <= S_FIN;
						end else if (cnt_q == CW'(1)) begin
							state_q <= S_SINGLE;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SINGLE: state_q <= S_FIN;
				S_SRD:    state_q <= S_SCMP;
				S_SCMP: begin
					if (hit || (CW'(idx_q + 1'b1) == cnt_q)) begin
						state_q <= S_RD0;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_RD0:  state_q <= S_CAP0;
				S_CAP0: state_q <= S_CAP1;
				S_CAP1: state_q <= S_PREP;
				S_PREP: state_q <= (den == '0) ? S_MUL : S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (chunk_q == 2'd3) begin
						state_q <= S_MQ;
					end
				end
				S_MQ: state_q <= S_MV;
				S_MV: state_q <= (comp_q == 2'd2) ? S_FIN : S_MUL;
				S_FIN: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire
